### hw/rtl/lzssd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants, command format and state encodings.
// ----------------------------------------------------------------------------
package lzssd_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int DIST_W    = WIN_AW + 1;
  localparam int SIZE_BITS = 24;
  localparam int LEN_W     = 5;
  localparam int LEN_BIAS  = 3;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PW    = $clog2(CMD_DEPTH);
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  // one decoded token: a literal or a back-reference copy
  typedef struct packed {
    logic                is_copy;
    logic [7:0]          lit;
    logic [LEN_W-1:0]    len;
    logic [DIST_W-1:0]   distance;
    logic                last;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_PAIR   = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ENG_IDLE = 3'b001,
    ENG_READ = 3'b010,
    ENG_EMIT = 3'b100
  } eng_state_e;

endpackage

### hw/rtl/lzssd_parser.sv
// ----------------------------------------------------------------------------
// LZSS decompressor token parser
// Takes stream bytes, tracks header, flags and size, emits literal/copy tokens.
// ----------------------------------------------------------------------------
module lzssd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  output logic                cmd_push_o,
  output lzssd_pkg::cmd_t     cmd_o,
  input  logic                cmd_full_i
);

  lzssd_pkg::phase_e                   phase_q, phase_d;
  logic [1:0]                          hidx_q, hidx_d;
  logic [lzssd_pkg::SIZE_BITS-1:0]     rem_q, rem_d;
  logic [7:0]                          flag_bits_q, flag_bits_d;
  logic [3:0]                          flags_left_q, flags_left_d;
  logic [7:0]                          pair_high_q, pair_high_d;

  logic                                accept;
  logic [4:0]                          hdr_sh;
  logic [lzssd_pkg::SIZE_BITS-1:0]     hdr_new;
  logic [lzssd_pkg::LEN_W-1:0]         len_w;
  logic [lzssd_pkg::LEN_W-1:0]         eff_len;
  logic                                copy_last;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign hdr_sh  = {hidx_q - 2'd1, 3'b000};
  assign hdr_new = rem_q | (lzssd_pkg::SIZE_BITS'(in_byte_i) << hdr_sh);

  assign len_w     = {1'b0, pair_high_q[7:4]} + lzssd_pkg::LEN_W'(lzssd_pkg::LEN_BIAS);
  assign copy_last = rem_q <= lzssd_pkg::SIZE_BITS'(len_w);
  assign eff_len   = copy_last ? rem_q[lzssd_pkg::LEN_W-1:0] : len_w;

  always_comb begin
    phase_d      = phase_q;
    hidx_d       = hidx_q;
    rem_d        = rem_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    pair_high_d  = pair_high_q;
    cmd_push_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.lit    = in_byte_i;

    if (accept) begin
      case (phase_q)
        lzssd_pkg::PH_BODY: begin
          if (flags_left_q == 4'd0) begin
            flag_bits_d  = in_byte_i;
            flags_left_d = 4'd8;
          end else if (!flag_bits_q[7]) begin
            cmd_push_o   = 1'b1;
            cmd_o.last   = (rem_q == lzssd_pkg::SIZE_BITS'(1));
            rem_d        = rem_q - lzssd_pkg::SIZE_BITS'(1);
            if (cmd_o.last) begin
              phase_d      = lzssd_pkg::PH_HEADER;
              hidx_d       = 2'd0;
              flags_left_d = 4'd0;
            end else begin
              flag_bits_d  = {flag_bits_q[6:0], 1'b0};
              flags_left_d = flags_left_q - 4'd1;
            end
          end else begin
            pair_high_d = in_byte_i;
            phase_d     = lzssd_pkg::PH_PAIR;
          end
        end
        lzssd_pkg::PH_PAIR: begin
          cmd_push_o     = 1'b1;
          cmd_o.is_copy  = 1'b1;
          cmd_o.len      = eff_len;
          cmd_o.distance = {1'b0, pair_high_q[3:0], in_byte_i} + lzssd_pkg::DIST_W'(1);
          cmd_o.last     = copy_last;
          rem_d          = rem_q - lzssd_pkg::SIZE_BITS'(eff_len);
          if (copy_last) begin
            phase_d      = lzssd_pkg::PH_HEADER;
            hidx_d       = 2'd0;
            flags_left_d = 4'd0;
          end else begin
            phase_d      = lzssd_pkg::PH_BODY;
            flag_bits_d  = {flag_bits_q[6:0], 1'b0};
            flags_left_d = flags_left_q - 4'd1;
          end
        end
        default: begin
          phase_d = lzssd_pkg::PH_HEADER;
          if (hidx_q == 2'd0) begin
            rem_d  = '0;
            hidx_d = 2'd1;
          end else begin
            rem_d = hdr_new;
            if (hidx_q == 2'd3) begin
              hidx_d       = 2'd0;
              flags_left_d = 4'd0;
              flag_bits_d  = 8'd0;
              if (hdr_new != '0) begin
                phase_d = lzssd_pkg::PH_BODY;
              end
            end else begin
              hidx_d = hidx_q + 2'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lzssd_pkg::PH_HEADER;
      hidx_q       <= 2'd0;
      rem_q        <= '0;
      flag_bits_q  <= 8'd0;
      flags_left_q <= 4'd0;
      pair_high_q  <= 8'd0;
    end else begin
      phase_q      <= phase_d;
      hidx_q       <= hidx_d;
      rem_q        <= rem_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      pair_high_q  <= pair_high_d;
    end
  end

`ifndef SYNTHESIS
  a_body_owes_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lzssd_pkg::PH_BODY || phase_q == lzssd_pkg::PH_PAIR) |-> rem_q != '0)
    else $error("body phase with nothing owed");
`endif

endmodule

### hw/rtl/lzssd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// LZSS decompressor token queue
// Short register queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzssd_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lzssd_pkg::cmd_t   push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lzssd_pkg::cmd_t   head_o
);

  lzssd_pkg::cmd_t                  mem_q [lzssd_pkg::CMD_DEPTH];
  logic [lzssd_pkg::CMD_PW-1:0]     wr_q, rd_q;
  logic [lzssd_pkg::CMD_CW-1:0]     cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = cnt_q == lzssd_pkg::CMD_CW'(lzssd_pkg::CMD_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == lzssd_pkg::CMD_PW'(lzssd_pkg::CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == lzssd_pkg::CMD_PW'(lzssd_pkg::CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + lzssd_pkg::CMD_CW'(do_push) - lzssd_pkg::CMD_CW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lzssd_pkg::CMD_CW'(lzssd_pkg::CMD_DEPTH))
    else $error("token queue count out of range");
`endif

endmodule

### hw/rtl/lzssd_copy_engine.sv
// ----------------------------------------------------------------------------
// LZSS decompressor copy engine
// Executes tokens against the 4 KiB history and drives the output register.
// ----------------------------------------------------------------------------
module lzssd_copy_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  lzssd_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              is_last_o
);

  lzssd_pkg::eng_state_e              state_q, state_d;
  logic [lzssd_pkg::WIN_AW-1:0]       wp_q, wp_d;
  logic [lzssd_pkg::DIST_W-1:0]       prod_q, prod_d;
  logic [lzssd_pkg::LEN_W-1:0]        len_q, len_d;
  logic [lzssd_pkg::DIST_W-1:0]       dist_q, dist_d;
  logic                               last_q, last_d;
  logic                               out_valid_q, out_valid_d;
  logic [7:0]                         out_byte_q, out_byte_d;
  logic                               out_last_q, out_last_d;

  logic [7:0]                         hist_q [lzssd_pkg::WIN_DEPTH];
  logic [7:0]                         rd_data_q;
  logic                               mem_we, mem_re;
  logic [7:0]                         mem_wd;
  logic [lzssd_pkg::WIN_AW-1:0]       mem_ra;

  logic                               out_free;
  logic                               emit;
  logic                               emit_last;
  logic [7:0]                         emit_byte;

  assign out_free = !out_valid_q || !out_stall_i;
  assign mem_ra   = wp_q - dist_q[lzssd_pkg::WIN_AW-1:0];
  assign mem_wd   = emit_byte;
  assign mem_we   = emit;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    prod_d      = prod_q;
    len_d       = len_q;
    dist_d      = dist_q;
    last_d      = last_q;
    cmd_pop_o   = 1'b0;
    mem_re      = 1'b0;
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_byte   = cmd_i.lit;

    case (state_q)
      lzssd_pkg::ENG_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_copy) begin
            cmd_pop_o = 1'b1;
            len_d     = cmd_i.len;
            dist_d    = cmd_i.distance;
            last_d    = cmd_i.last;
            state_d   = lzssd_pkg::ENG_READ;
          end else if (out_free) begin
            cmd_pop_o = 1'b1;
            emit      = 1'b1;
            emit_last = cmd_i.last;
          end
        end
      end
      lzssd_pkg::ENG_READ: begin
        mem_re  = 1'b1;
        state_d = lzssd_pkg::ENG_EMIT;
      end
      lzssd_pkg::ENG_EMIT: begin
        emit_byte = (dist_q > prod_q) ? lzssd_pkg::FILL_BYTE : rd_data_q;
        if (out_free) begin
          emit      = 1'b1;
          emit_last = last_q && (len_q == lzssd_pkg::LEN_W'(1));
          len_d     = len_q - lzssd_pkg::LEN_W'(1);
          state_d   = (len_q == lzssd_pkg::LEN_W'(1)) ? lzssd_pkg::ENG_IDLE
                                                      : lzssd_pkg::ENG_READ;
        end
      end
      default: begin
        state_d = lzssd_pkg::ENG_IDLE;
      end
    endcase

    if (emit) begin
      wp_d = wp_q + 1'b1;
      if (emit_last) begin
        prod_d = '0;
      end else if (prod_q != lzssd_pkg::DIST_W'(lzssd_pkg::WIN_DEPTH)) begin
        prod_d = prod_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_q[wp_q] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= hist_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    len_q      <= len_d;
    dist_q     <= dist_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzssd_pkg::ENG_IDLE;
      wp_q        <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lzssd_pkg::ENG_READ |=> state_q == lzssd_pkg::ENG_EMIT)
    else $error("history read not followed by emit");
  a_last_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> prod_q == '0)
    else $error("produced count not cleared at end of stream");
  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_q <= lzssd_pkg::DIST_W'(lzssd_pkg::WIN_DEPTH))
    else $error("produced count beyond window");
  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

### hw/rtl/lzss_stream_decompressor_top.sv
// ----------------------------------------------------------------------------
// LZSS stream decompressor, top level
// Header/flag parser, token queue and 4 KiB history copy engine.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------
//   in      | input     | in_valid_i / in_stall_o   | in_byte_i
//   out     | output    | out_valid_o / out_stall_i | out_byte_o, is_last_o
//
// Input bytes are taken one per cycle while the two-entry token queue has room.
// A literal is emitted straight from idle; a copy is loaded first, then each
// byte takes a registered history read, then emit and write back.
// Reset is asynchronous, active low; history contents are not cleared.
// Output stalls back up through the queue to in_stall_o.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_last_o
);

  logic             cmd_push;
  lzssd_pkg::cmd_t  cmd_in;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_valid;
  lzssd_pkg::cmd_t  cmd_head;

  lzssd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  lzssd_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .valid_o     (cmd_valid),
    .head_o      (cmd_head)
  );

  lzssd_copy_engine u_copy_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .is_last_o   (is_last_o)
  );

endmodule

### dv/lzss_stream_decompressor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZSS stream decompressor testbench
// Feeds compressed streams, a short directed table and then random
// well-formed streams, with random idling on both channels. Each output
// transfer is checked against typed table rows or a behavioural decoder.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_top_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RAND_ITEMS  = 390;
  localparam int unsigned QUIET_AFTER = 330;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int          N_DIRECTED  = 27;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

  // typed rows: n copies of val, last flag on the final one when fin is set
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [7:0] val;
    logic [4:0] n;
    logic       fin;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // size 3, one long copy before start: cut off at the size
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h03, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h80, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'hF0, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b1, 8'hFF, 5'd3, 1'b1},
    // zero size
    '{8'h5A, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    // size 5: literal, overlapping copy, literal; spare flags dropped
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h05, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h40, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b1, 8'h00, 5'd1, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'hFF, 1'b1, 8'hFF, 5'd1, 1'b1},
    // size 2, longest copy at the full distance
    '{8'hFF, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h02, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'hFF, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'hFF, 1'b0, 8'h00, 5'd0, 1'b0},
    '{8'hFF, 1'b1, 8'hFF, 5'd2, 1'b1}
  };

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       is_last;

  lzss_stream_decompressor_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .is_last_o   (is_last)
  );

  // decoder state
  lzssd_pkg::phase_e dec_phase;
  logic [1:0]  dec_hdr_idx;
  logic [23:0] dec_owed;
  logic [23:0] dec_made;
  logic [7:0]  dec_flags;
  logic [3:0]  dec_flags_left;
  logic [7:0]  dec_pair_hi;
  logic [7:0]  dec_window [lzssd_pkg::WIN_DEPTH];
  logic [11:0] dec_wptr;

  out_t        step_bytes [$];
  out_t        owed_bytes [$];
  logic [7:0]  stream_bytes [$];

  logic        cur_typed = 1'b0;
  logic [7:0]  cur_val   = 8'h00;
  logic [4:0]  cur_n     = 5'd0;
  logic        cur_fin   = 1'b0;

  bit          idle_en   = 1'b1;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned rand_items = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  task window_put(input logic [7:0] v, output bit fin);
    dec_window[dec_wptr] = v;
    dec_wptr = dec_wptr + 12'd1;
    dec_made = dec_made + 24'd1;
    dec_owed = dec_owed - 24'd1;
    fin = (dec_owed == 24'd0);
    step_bytes.push_back('{data: v, last: fin});
    if (fin) begin
      dec_phase      = lzssd_pkg::PH_HEADER;
      dec_hdr_idx    = 2'd0;
      dec_flags_left = 4'd0;
    end
  endtask

  task shift_flag;
    dec_flags      = dec_flags << 1;
    dec_flags_left = dec_flags_left - 4'd1;
  endtask

  task decode_byte(input logic [7:0] b);
    logic [15:0] code;
    logic [4:0]  len;
    logic [12:0] distance;
    logic [11:0] rd;
    logic [7:0]  v;
    bit          fin;
    step_bytes.delete();
    fin = 1'b0;
    case (dec_phase)
      lzssd_pkg::PH_BODY: begin
        if (dec_flags_left == 4'd0) begin
          dec_flags      = b;
          dec_flags_left = 4'd8;
        end else if (!dec_flags[7]) begin
          window_put(b, fin);
          if (!fin) shift_flag();
        end else begin
          dec_pair_hi = b;
          dec_phase   = lzssd_pkg::PH_PAIR;
        end
      end
      lzssd_pkg::PH_PAIR: begin
        code     = {dec_pair_hi, b};
        len      = {1'b0, code[15:12]} + lzssd_pkg::LEN_W'(lzssd_pkg::LEN_BIAS);
        distance = {1'b0, code[11:0]} + 13'd1;
        for (int j = 0; j < len && !fin; j++) begin
          rd = dec_wptr - distance[11:0];
          v  = ({11'd0, distance} > dec_made) ? lzssd_pkg::FILL_BYTE : dec_window[rd];
          window_put(v, fin);
        end
        if (!fin) begin
          dec_phase = lzssd_pkg::PH_BODY;
          shift_flag();
        end
      end
      default: begin
        dec_phase = lzssd_pkg::PH_HEADER;
        case (dec_hdr_idx)
          2'd0: begin
            dec_owed    = 24'd0;
            dec_hdr_idx = 2'd1;
          end
          2'd1: begin
            dec_owed[7:0] = b;
            dec_hdr_idx   = 2'd2;
          end
          2'd2: begin
            dec_owed[15:8] = b;
            dec_hdr_idx    = 2'd3;
          end
          default: begin
            dec_owed[23:16] = b;
            dec_hdr_idx     = 2'd0;
            dec_made        = 24'd0;
            dec_flags_left  = 4'd0;
            dec_flags       = 8'd0;
            if (dec_owed != 24'd0) dec_phase = lzssd_pkg::PH_BODY;
          end
        endcase
      end
    endcase
  endtask

  // both channels observed at the rising edge, input side first
  always @(posedge clk) begin
    out_t want;
    if (in_valid && !in_stall) begin
      decode_byte(in_byte);
      if (cur_typed) begin
        for (int k = 0; k < cur_n; k++)
          owed_bytes.push_back('{data: cur_val, last: cur_fin && (k == cur_n - 1)});
      end else begin
        foreach (step_bytes[k]) owed_bytes.push_back(step_bytes[k]);
      end
    end
    if (out_valid && !out_stall) begin
      if (owed_bytes.size() == 0) begin
        report_mismatch("unexpected transfer, byte", out_byte, 0);
      end else begin
        want = owed_bytes.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (is_last !== want.last) report_mismatch("is_last", is_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d transfers outstanding", owed_bytes.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task send_byte(input logic [7:0] b, input logic typed, input logic [7:0] val,
                 input logic [4:0] n, input logic fin);
    int unsigned gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    cur_typed = typed;
    cur_val   = val;
    cur_n     = n;
    cur_fin   = fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task drain_outputs;
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(negedge clk);
  endtask

  // builds a well-formed stream that ends exactly at its size
  task compose_stream(input int unsigned size);
    int unsigned made;
    int unsigned len;
    int unsigned distance;
    int unsigned reach;
    logic [7:0]  flags;
    logic [15:0] code;
    stream_bytes.delete();
    stream_bytes.push_back(8'($urandom));
    stream_bytes.push_back(size[7:0]);
    stream_bytes.push_back(size[15:8]);
    stream_bytes.push_back(size[23:16]);
    made = 0;
    while (made < size) begin
      flags = 8'($urandom);
      stream_bytes.push_back(flags);
      for (int k = 7; k >= 0 && made < size; k--) begin
        if (!flags[k]) begin
          stream_bytes.push_back(8'($urandom));
          made++;
        end else begin
          len   = $urandom_range(0, 15);
          reach = (made < lzssd_pkg::WIN_DEPTH) ? made : lzssd_pkg::WIN_DEPTH;
          case ($urandom_range(0, 5))
            0:       distance = $urandom_range(1, lzssd_pkg::WIN_DEPTH);
            1:       distance = $urandom_range(1, 3);
            default: distance = (reach == 0) ? $urandom_range(1, lzssd_pkg::WIN_DEPTH)
                                             : $urandom_range(1, reach);
          endcase
          code = {len[3:0], 12'(distance - 1)};
          stream_bytes.push_back(code[15:8]);
          stream_bytes.push_back(code[7:0]);
          made += (len + 3 < size - made) ? len + 3 : size - made;
        end
      end
    end
  endtask

  initial begin
    int unsigned size;
    int unsigned size_cap;
    bit          paused;
    dec_phase      = lzssd_pkg::PH_HEADER;
    dec_hdr_idx    = 2'd0;
    dec_owed       = 24'd0;
    dec_made       = 24'd0;
    dec_flags      = 8'd0;
    dec_flags_left = 4'd0;
    dec_pair_hi    = 8'd0;
    dec_wptr       = 12'd0;
    foreach (dec_window[i]) dec_window[i] = 8'd0;
    paused = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++)
      send_byte(DIRECTED[r].b, DIRECTED[r].typed, DIRECTED[r].val,
                DIRECTED[r].n, DIRECTED[r].fin);
    drain_outputs();

    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       size = 0;
        7, 8:    size = $urandom_range(41, 200);
        9:       size = $urandom_range(201, 700);
        default: size = $urandom_range(1, 40);
      endcase
      // cap the stream size at three quarters of what is left of the item budget
      size_cap = (RAND_ITEMS - rand_items) * 3 / 4;
      if (size > size_cap) size = size_cap;
      compose_stream(size);
      if (rand_items > QUIET_AFTER) idle_en = 1'b0;
      else idle_en = ($urandom_range(0, 3) != 0);
      foreach (stream_bytes[i]) begin
        send_byte(stream_bytes[i], 1'b0, 8'h00, 5'd0, 1'b0);
        rand_items++;
      end
      if (!paused && rand_items >= RAND_ITEMS / 2) begin
        drain_outputs();
        paused = 1'b1;
      end
    end

    // largest size: the stream is left open at the end of the run
    idle_en = 1'b0;
    compose_stream(40);
    stream_bytes[1] = 8'hFF;
    stream_bytes[2] = 8'hFF;
    stream_bytes[3] = 8'hFF;
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], 1'b0, 8'h00, 5'd0, 1'b0);

    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lzssd_pkg.sv
hw/rtl/lzssd_parser.sv
hw/rtl/lzssd_cmd_fifo.sv
hw/rtl/lzssd_copy_engine.sv
hw/rtl/lzss_stream_decompressor_top.sv
dv/lzss_stream_decompressor_top_tb.sv
